// ===== src/cmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types and constants of the Catmull-Rom spline position unit.
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  // curve parameter, unsigned Q0.16 with one extra bit for 1.0
  localparam int T_W    = 17;
  localparam int FRAC_W = 16;
  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  // fewest points that give a valid curve
  localparam int MIN_POINTS = 4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  // per-stage load strobes of the evaluation pipeline
  typedef struct packed {
    logic coef;
    logic mul1;
    logic add1;
    logic mul2;
    logic add2;
    logic mul3;
    logic add3;
    logic fin;
  } cmr_adv_t;

endpackage

// ===== src/cmr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cmr_seg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_seg
// Segment lookup: splits the global parameter into segment and local
// parameter and forms the four control point addresses.
// ----------------------------------------------------------------------------
module cmr_seg #(
  parameter int MAX_POINTS = cmr_pkg::MAX_POINTS_DEF
) (
  input  logic [$clog2(MAX_POINTS+1)-1:0]    count_i,
  input  logic [cmr_pkg::T_W-1:0]            t_i,
  output logic [3:0][$clog2(MAX_POINTS)-1:0] idx_o,
  output logic [cmr_pkg::T_W-1:0]            u_o,
  output logic                               invalid_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int UG_W  = cmr_pkg::T_W + IDX_W;
  localparam int F_W   = cmr_pkg::FRAC_W;

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] div;
  logic [IDX_W-1:0] cap;
  logic [cmr_pkg::T_W-1:0] tc;
  logic [UG_W-1:0]  uglob;
  logic [UG_W-1:0]  seg_base;
  logic [IDX_W:0]   seg_raw;
  logic [IDX_W-1:0] seg;
  logic [CNT_W:0]   seg_p2;

  always_comb begin
    n = (count_i > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_i;
    invalid_o = n < CNT_W'(cmr_pkg::MIN_POINTS);
    tc = (t_i > cmr_pkg::ONE_Q16) ? cmr_pkg::ONE_Q16 : t_i;
    n_m1 = n - CNT_W'(1);
    div = n_m1[IDX_W-1:0];
    cap = div - IDX_W'(1);
    uglob = UG_W'(tc) * UG_W'(div);
    seg_raw = uglob[UG_W-1:F_W];
    seg = (seg_raw > {1'b0, cap}) ? cap : seg_raw[IDX_W-1:0];
    seg_base = UG_W'(seg) << F_W;
    u_o = cmr_pkg::T_W'(uglob - seg_base);
    seg_p2 = (CNT_W+1)'(seg) + (CNT_W+1)'(2);
    idx_o[1] = seg;
    idx_o[2] = seg + IDX_W'(1);
    // repeat the end points at both ends of the curve
    idx_o[0] = (seg == '0) ? seg : seg - IDX_W'(1);
    idx_o[3] = (seg_p2 >= {1'b0, n}) ? idx_o[2] : seg_p2[IDX_W-1:0];
  end

endmodule

// ===== src/cmr_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_axis
// One axis of the cubic: coefficients, three Horner steps each split into
// a multiply stage and a round-and-add stage, then halving and saturation.
// ----------------------------------------------------------------------------
module cmr_axis #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  cmr_pkg::cmr_adv_t            adv_i,
  input  logic signed [COORD_BITS-1:0] p0_i,
  input  logic signed [COORD_BITS-1:0] p1_i,
  input  logic signed [COORD_BITS-1:0] p2_i,
  input  logic signed [COORD_BITS-1:0] p3_i,
  input  logic [cmr_pkg::T_W-1:0]      u1_i,
  input  logic [cmr_pkg::T_W-1:0]      u2_i,
  input  logic [cmr_pkg::T_W-1:0]      u3_i,
  input  logic                         invalid_i,
  output logic signed [COORD_BITS-1:0] out_o
);

  localparam int AW = COORD_BITS + 6;
  localparam int PW = AW + cmr_pkg::T_W;
  localparam int F_W = cmr_pkg::FRAC_W;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] a);
    mag = a[AW-1] ? AW'(-a) : AW'(a);
  endfunction

  // round to nearest, ties away from zero, and restore the sign
  function automatic logic signed [AW-1:0] rescale(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] r;
    logic [AW-1:0] m;
    r = p + PW'(32'h8000);
    m = r[AW-1+F_W:F_W];
    rescale = neg ? -$signed(m) : $signed(m);
  endfunction

  logic signed [AW-1:0] s0, s1, s2, s3;
  logic signed [AW-1:0] e3_q, e2_q, e1_q, e0_q;
  logic                 neg3_q, neg5_q, neg7_q;
  logic [PW-1:0]        prod3_q, prod5_q, prod7_q;
  logic signed [AW-1:0] e2_3_q, e1_3_q, e0_3_q;
  logic signed [AW-1:0] acc4_q, e1_4_q, e0_4_q;
  logic signed [AW-1:0] e1_5_q, e0_5_q;
  logic signed [AW-1:0] acc6_q, e0_6_q;
  logic signed [AW-1:0] e0_7_q;
  logic signed [AW-1:0] acc8_q;
  logic signed [COORD_BITS-1:0] out_q;
  logic [AW-1:0]        fmag;
  logic [AW:0]          fsum;
  logic [AW-1:0]        fh;
  logic signed [AW-1:0] half;
  logic signed [AW-1:0] sat;

  assign s0 = AW'(p0_i);
  assign s1 = AW'(p1_i);
  assign s2 = AW'(p2_i);
  assign s3 = AW'(p3_i);

  always_comb begin
    fmag = mag(acc8_q);
    fsum = {1'b0, fmag} + (AW+1)'(1);
    fh = fsum[AW:1];
    half = acc8_q[AW-1] ? -$signed(fh) : $signed(fh);
    if (half > SAT_HI) begin
      sat = SAT_HI;
    end else if (half < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = half;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.coef) begin
      e3_q <= -s0 + (s1 <<< 1) + s1 - (s2 <<< 1) - s2 + s3;
      e2_q <= (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
      e1_q <= s2 - s0;
      e0_q <= s1 <<< 1;
    end
    if (adv_i.mul1) begin
      neg3_q  <= e3_q[AW-1];
      prod3_q <= PW'(mag(e3_q)) * PW'(u1_i);
      e2_3_q  <= e2_q;
      e1_3_q  <= e1_q;
      e0_3_q  <= e0_q;
    end
    if (adv_i.add1) begin
      acc4_q <= rescale(prod3_q, neg3_q) + e2_3_q;
      e1_4_q <= e1_3_q;
      e0_4_q <= e0_3_q;
    end
    if (adv_i.mul2) begin
      neg5_q  <= acc4_q[AW-1];
      prod5_q <= PW'(mag(acc4_q)) * PW'(u2_i);
      e1_5_q  <= e1_4_q;
      e0_5_q  <= e0_4_q;
    end
    if (adv_i.add2) begin
      acc6_q <= rescale(prod5_q, neg5_q) + e1_5_q;
      e0_6_q <= e0_5_q;
    end
    if (adv_i.mul3) begin
      neg7_q  <= acc6_q[AW-1];
      prod7_q <= PW'(mag(acc6_q)) * PW'(u3_i);
      e0_7_q  <= e0_6_q;
    end
    if (adv_i.add3) begin
      acc8_q <= rescale(prod7_q, neg7_q) + e0_7_q;
    end
    if (adv_i.fin) begin
      out_q <= invalid_i ? '0 : sat[COORD_BITS-1:0];
    end
  end

  assign out_o = out_q;

endmodule

// ===== src/catmull_rom_spline_position.sv =====
`timescale 1ns / 1ps
// an evaluate request passes nine register stages from acceptance to its result
// throughput: one request per cycle while in_stall_o is low, writes and evaluates alike
// the four point reads per cycle are served by four copies of the point table
// reset clears the point count and the pipeline valid bits; table contents
// stay undefined until written
// ----------------------------------------------------------------------------
// catmull_rom_spline_position
// Uniform Catmull-Rom spline position unit over a table of 3D points.
// ----------------------------------------------------------------------------
module catmull_rom_spline_position #(
  parameter int MAX_POINTS = cmr_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   point_count_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [$clog2(MAX_POINTS)-1:0]     point_index_i,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  input  logic [cmr_pkg::T_W-1:0]           position_t_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic signed [COORD_BITS-1:0]      out_z_o,
  output logic                              invalid_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PT_W  = 3 * COORD_BITS;
  localparam int NS    = 9;

  logic [CNT_W-1:0] point_count_q;
  logic [NS:1] v_q, v_d, rdy, load;
  logic [3:0][IDX_W-1:0] idx;
  logic [cmr_pkg::T_W-1:0] seg_u;
  logic seg_inv;
  logic [cmr_pkg::T_W-1:0] u_q [1:6];
  logic inv_q [1:8];
  logic acc_in, wr_en;
  logic [PT_W-1:0] rd_data [4];
  cmr_pkg::cmr_adv_t adv;

  function automatic logic cmd_is_write(input logic c);
    cmd_is_write = cmr_pkg::cmd_e'(c) == cmr_pkg::CMD_WRITE;
  endfunction

  assign acc_in = in_valid_i && !in_stall_o;
  assign wr_en  = acc_in && (cmd_is_write(command_i))
                  && ({1'b0, point_index_i} < (IDX_W+1)'(MAX_POINTS));

  // stage ready chain: a stage can load when empty or when it moves on
  always_comb begin
    rdy[NS] = !v_q[NS] || !out_stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    load[1] = in_valid_i && (cmr_pkg::cmd_e'(command_i) == cmr_pkg::CMD_EVAL) && rdy[1];
    for (int k = 2; k <= NS; k++) begin
      load[k] = v_q[k-1] && rdy[k];
    end
    for (int k = 1; k < NS; k++) begin
      v_d[k] = load[k] || (v_q[k] && !rdy[k+1]);
    end
    v_d[NS] = load[NS] || (v_q[NS] && out_stall_i);
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      point_count_q <= '0;
    end else begin
      v_q <= v_d;
      if (cfg_we_i) begin
        point_count_q <= point_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      u_q[1]   <= seg_u;
      inv_q[1] <= seg_inv;
    end
    for (int k = 2; k <= 6; k++) begin
      if (load[k]) begin
        u_q[k] <= u_q[k-1];
      end
    end
    for (int k = 2; k <= 8; k++) begin
      if (load[k]) begin
        inv_q[k] <= inv_q[k-1];
      end
    end
    if (load[NS]) begin
      invalid_o <= inv_q[8];
    end
  end

  cmr_seg #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seg (
    .count_i  (point_count_q),
    .t_i      (position_t_i),
    .idx_o    (idx),
    .u_o      (seg_u),
    .invalid_o(seg_inv)
  );

  for (genvar g = 0; g < 4; g++) begin : g_tab
    cmr_ram #(
      .WIDTH(PT_W),
      .DEPTH(MAX_POINTS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en),
      .waddr_i(point_index_i),
      .wdata_i({point_z_i, point_y_i, point_x_i}),
      .re_i   (load[1]),
      .raddr_i(idx[g]),
      .rdata_o(rd_data[g])
    );
  end

  assign adv.coef = load[2];
  assign adv.mul1 = load[3];
  assign adv.add1 = load[4];
  assign adv.mul2 = load[5];
  assign adv.add2 = load[6];
  assign adv.mul3 = load[7];
  assign adv.add3 = load[8];
  assign adv.fin  = load[9];

  logic signed [COORD_BITS-1:0] axis_out [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    cmr_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .p0_i     (rd_data[0][a*COORD_BITS +: COORD_BITS]),
      .p1_i     (rd_data[1][a*COORD_BITS +: COORD_BITS]),
      .p2_i     (rd_data[2][a*COORD_BITS +: COORD_BITS]),
      .p3_i     (rd_data[3][a*COORD_BITS +: COORD_BITS]),
      .u1_i     (u_q[2]),
      .u2_i     (u_q[4]),
      .u3_i     (u_q[6]),
      .invalid_i(inv_q[8]),
      .out_o    (axis_out[a])
    );
  end

  assign out_valid_o = v_q[NS];
  assign out_x_o = axis_out[0];
  assign out_y_o = axis_out[1];
  assign out_z_o = axis_out[2];

endmodule

// ===== src/cmr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_checker
// Port-level checks of the spline position unit, bound to the top level.
// ----------------------------------------------------------------------------
module cmr_checker #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] out_x_o,
  input logic [COORD_BITS-1:0] out_y_o,
  input logic [COORD_BITS-1:0] out_z_o,
  input logic                  invalid_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o) && $stable(invalid_o))
    else $error("stalled result changed");

  // an invalid result carries a zero position
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("invalid result with nonzero position");

  // input only stalls when the full pipeline waits on the output side
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an input stall with the output released must not last into the next cycle
  a_stall_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall persisted after output was released");

endmodule

bind catmull_rom_spline_position cmr_checker #(
  .COORD_BITS(COORD_BITS)
) u_cmr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_x_o    (out_x_o),
  .out_y_o    (out_y_o),
  .out_z_o    (out_z_o),
  .invalid_o  (invalid_o)
);
